// ----- rtl/core/best_hamming_window_match_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the best Hamming window match block
// Shared concurrent property forms for the files that check their own logic.
// ----------------------------------------------------------------------------
`ifndef BEST_HAMMING_WINDOW_MATCH_DEFINES_SVH
`define BEST_HAMMING_WINDOW_MATCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BHWM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bhwm: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BHWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bhwm: next-cycle check failed");

`endif

// ----- rtl/core/bhwm_pkg.sv -----
// ----------------------------------------------------------------------------
// bhwm_pkg
// Shared types and constants of the best Hamming window match block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhwm_pkg;

   localparam int MAX_PATTERN_DEF = 32;
   localparam int SYM_W           = 8;
   localparam int OUT_W           = 6;

   localparam logic CMD_PATTERN = 1'b0;
   localparam logic CMD_GENOME  = 1'b1;

   typedef struct packed {
      logic             command;
      logic [SYM_W-1:0] symbol;
      logic             last;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] best_matches;
      logic [OUT_W-1:0] pattern_length;
      logic             genome_too_short;
   } rsp_type;

   // pattern byte and occupancy handed along the cell row
   typedef struct packed {
      logic             active;
      logic [SYM_W-1:0] symbol;
   } link_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic step;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/best_hamming_window_match.sv -----
// ----------------------------------------------------------------------------
// best_hamming_window_match: one request per cycle, busy is low except in reset.
// The result leaves in the cycle after the last genome request, strobed once.
// Cell row updates every window count per genome byte; receiver cannot stall.
// Reset (synchronous) empties the pattern and clears all counts and positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "best_hamming_window_match_defines.svh"

module best_hamming_window_match
   import bhwm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int              CW      = $clog2(MAX_PATTERN + 1);
   localparam logic [CW-1:0]   MAX_LEN = CW'(MAX_PATTERN);

   // Row layout: pattern bytes shift in at cell 0, so cell 0 holds the newest
   // pattern byte and the full-window count always ends up in cell 0.
   // Counts flow from higher cells down toward cell 0, one cell per genome byte.

   logic                busy_ff;
   logic [CW-1:0]       length_ff, length_in;
   logic [CW-1:0]       position_ff, position_in;
   logic [CW-1:0]       best_ff, best_in;
   logic                done_ff, done_in;
   logic                rsp_strobe_ff;
   rsp_type             rsp_item_ff, rsp_item_in;

   logic                accept, is_pat, is_gen, new_pat, gen_last;
   logic [CW-1:0]       len_base;
   logic [CW-1:0]       pos_next;
   logic [CW-1:0]       best_cand;
   logic                full_window;
   logic                too_short;
   cell_ctrl_type       ctrl;

   link_type            links    [MAX_PATTERN];
   link_type            up_links [MAX_PATTERN];
   logic [CW-1:0]       counts   [MAX_PATTERN];
   logic [CW-1:0]       up_counts[MAX_PATTERN];
   logic [CW-1:0]       next_counts[MAX_PATTERN];
   logic [MAX_PATTERN-1:0] active_vec;

   // ---------------- request decode ----------------
   always_comb begin
      accept   = start && !busy_ff;
      is_pat   = accept && (req_item.command == CMD_PATTERN);
      is_gen   = accept && (req_item.command == CMD_GENOME);
      gen_last = is_gen && req_item.last;
      // a pattern byte after a closed pattern starts a fresh one
      new_pat  = is_pat && done_ff;
      len_base = new_pat ? '0 : length_ff;

      ctrl.load  = is_pat && (len_base < MAX_LEN);
      ctrl.clear = new_pat || gen_last;
      ctrl.step  = is_gen && (length_ff != '0);
   end

   // ---------------- cell row ----------------
   for (genvar c = 0; c < MAX_PATTERN; c++) begin : g_cell
      if (c == 0) begin : g_head
         // newest pattern byte enters here
         assign up_links[c].active = 1'b1;
         assign up_links[c].symbol = req_item.symbol;
      end else begin : g_body
         // drop the old pattern's occupancy when a new one starts
         assign up_links[c].active = links[c-1].active && !new_pat;
         assign up_links[c].symbol = links[c-1].symbol;
      end

      if (c == MAX_PATTERN - 1) begin : g_tail
         assign up_counts[c] = '0;
      end else begin : g_mid
         // an empty upper cell starts the window at zero
         assign up_counts[c] = links[c+1].active ? counts[c+1] : '0;
      end

      assign active_vec[c] = links[c].active;

      bhwm_cell #(
         .CNT_W (CW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .symbol     (req_item.symbol),
         .up_link    (up_links[c]),
         .up_count   (up_counts[c]),
         .link       (links[c]),
         .count      (counts[c]),
         .next_count (next_counts[c])
      );
   end

   // ---------------- window tracking and best count ----------------
   always_comb begin
      // position saturates at the pattern length
      pos_next    = (position_ff < length_ff) ? position_ff + CW'(1) : position_ff;
      full_window = (pos_next == length_ff);
      best_cand   = (full_window && (next_counts[0] > best_ff)) ? next_counts[0] : best_ff;
      if (!ctrl.step) begin
         best_cand = best_ff;
      end
      too_short   = (ctrl.step ? pos_next : position_ff) < length_ff;

      length_in = length_ff;
      if (is_pat) begin
         length_in = ctrl.load ? len_base + CW'(1) : len_base;
      end

      done_in = done_ff;
      if (is_pat) begin
         done_in = req_item.last;
      end else if (is_gen) begin
         done_in = 1'b1;
      end

      position_in = position_ff;
      best_in     = best_ff;
      if (ctrl.clear) begin
         position_in = '0;
         best_in     = '0;
      end else if (ctrl.step) begin
         position_in = pos_next;
         best_in     = best_cand;
      end

      // outputs wrap to their field width
      rsp_item_in.best_matches     = too_short ? '0 : OUT_W'(best_cand);
      rsp_item_in.pattern_length   = OUT_W'(length_ff);
      rsp_item_in.genome_too_short = too_short;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         length_ff     <= '0;
         position_ff   <= '0;
         best_ff       <= '0;
         done_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         length_ff     <= length_in;
         position_ff   <= position_in;
         best_ff       <= best_in;
         done_ff       <= done_in;
         rsp_strobe_ff <= gen_last;
      end
   end

   // result payload: hold until the next last genome byte
   always_ff @(posedge clock) begin
      if (gen_last) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // ---------------- assertions ----------------
   `BHWM_ASSERT_NEXT(a_rsp_after_last, clock, reset, gen_last, rsp_strobe_ff)
   `BHWM_ASSERT_NOW(a_rsp_has_cause, clock, reset, rsp_strobe_ff && !$past(reset), $past(gen_last))
   `BHWM_ASSERT_NOW(a_short_zero, clock, reset, rsp_strobe_ff && rsp_item_ff.genome_too_short, rsp_item_ff.best_matches == '0)
   `BHWM_ASSERT_NOW(a_pos_bounded, clock, reset, 1'b1, position_ff <= length_ff)
   `BHWM_ASSERT_NOW(a_row_fill, clock, reset, 1'b1, $countones(active_vec) == int'(length_ff))

endmodule

// ----- rtl/core/bhwm_cell.sv -----
// ----------------------------------------------------------------------------
// bhwm_cell
// One cell of the row: holds one pattern byte and one window's partial count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhwm_cell
   import bhwm_pkg::*;
#(
   parameter int CNT_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   input  logic [SYM_W-1:0] symbol,
   input  link_type         up_link,
   input  logic [CNT_W-1:0] up_count,
   output link_type         link,
   output logic [CNT_W-1:0] count,
   output logic [CNT_W-1:0] next_count
);

   logic             active_ff;
   logic [SYM_W-1:0] char_ff;
   logic [CNT_W-1:0] count_ff;
   logic             hit;

   always_comb begin
      hit        = active_ff && (symbol == char_ff);
      next_count = up_count + CNT_W'(hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (ctrl.load) begin
            active_ff <= up_link.active;
         end
         if (ctrl.clear) begin
            count_ff <= '0;
         end else if (ctrl.step) begin
            count_ff <= next_count;
         end
      end
   end

   // pattern byte: shift in on load
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         char_ff <= up_link.symbol;
      end
   end

   assign link.active = active_ff;
   assign link.symbol = char_ff;
   assign count       = count_ff;

endmodule

// ----- test/best_hamming_window_match_tb.sv -----
// ----------------------------------------------------------------------------
// best_hamming_window_match_tb
// Drives pattern and genome requests into the window match block and
// checks every strobed score. A scoreboard object tracks the pattern and
// the running window counts, predicts the score of each genome, and
// compares it with the block's output field by field. A short directed
// pass comes first, then randomized pattern/genome sequences with noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module best_hamming_window_match_tb;
   import bhwm_pkg::*;

   localparam int PATTERN_CAP  = MAX_PATTERN_DEF;
   localparam int STIM_DEPTH   = PATTERN_CAP + 8;
   localparam int ITEM_TARGET  = 700;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   // -------------------------------------------------------------------------
   // Scoreboard: follows the pattern load and the per-window match counts,
   // and holds the scores still to come out of the block.
   // -------------------------------------------------------------------------
   class best_match_tracker;
      logic [SYM_W-1:0] pattern [PATTERN_CAP];
      logic [OUT_W-1:0] held_length;
      logic [OUT_W-1:0] window_count [PATTERN_CAP];
      logic [OUT_W-1:0] position;
      logic [OUT_W-1:0] best;
      bit               pattern_closed;
      rsp_type          expected_scores [$];
      int unsigned      errors;

      function new();
         foreach (pattern[i]) pattern[i] = '0;
         held_length    = '0;
         pattern_closed = 1'b1;
         errors         = 0;
         clear_genome();
      endfunction

      function void clear_genome();
         foreach (window_count[i]) window_count[i] = '0;
         position = '0;
         best     = '0;
      endfunction

      // Update the model with one accepted request; queue a score on the
      // last genome byte.
      function void take_request(req_type r);
         int      len;
         bit      too_short;
         rsp_type score;
         if (r.command == CMD_PATTERN) begin
            // first byte after a closed pattern starts a fresh one
            if (pattern_closed) begin
               held_length    = '0;
               clear_genome();
               pattern_closed = 1'b0;
            end
            // bytes past capacity are dropped
            if (held_length < PATTERN_CAP) begin
               pattern[held_length] = r.symbol;
               held_length          = held_length + 1'b1;
            end
            if (r.last) pattern_closed = 1'b1;
            return;
         end
         // a genome byte closes any open pattern load
         pattern_closed = 1'b1;
         len = int'(held_length);
         if (len > 0) begin
            for (int k = len - 1; k > 0; k--)
               window_count[k] = window_count[k-1] + ((r.symbol == pattern[k]) ? 1 : 0);
            window_count[0] = (r.symbol == pattern[0]) ? 1 : 0;
            if (position < len) position = position + 1'b1;
            if (position >= len && window_count[len-1] > best) best = window_count[len-1];
         end
         if (!r.last) return;
         too_short              = position < len;
         score.best_matches     = too_short ? '0 : best;
         score.pattern_length   = OUT_W'(len);
         score.genome_too_short = too_short;
         expected_scores.push_back(score);
         clear_genome();
      endfunction

      // Compare one strobed score with the oldest prediction.
      function void check_score(rsp_type got);
         rsp_type want;
         if (expected_scores.size() == 0) begin
            $error("unexpected score: best_matches %0d pattern_length %0d too_short %0d",
                   got.best_matches, got.pattern_length, got.genome_too_short);
            errors++;
            return;
         end
         want = expected_scores.pop_front();
         if (got.best_matches !== want.best_matches) begin
            $error("best_matches: expected %0d, actual %0d",
                   want.best_matches, got.best_matches);
            errors++;
         end
         if (got.pattern_length !== want.pattern_length) begin
            $error("pattern_length: expected %0d, actual %0d",
                   want.pattern_length, got.pattern_length);
            errors++;
         end
         if (got.genome_too_short !== want.genome_too_short) begin
            $error("genome_too_short: expected %0d, actual %0d",
                   want.genome_too_short, got.genome_too_short);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_scores.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block
   // -------------------------------------------------------------------------
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   best_match_tracker tracker = new();

   // stimulus-side copy of the pattern, used to plant near-copies in genomes
   logic [SYM_W-1:0] stim_pattern [STIM_DEPTH];
   int unsigned      stim_length  = 0;
   logic [SYM_W-1:0] alphabet [4];
   bit               wide_symbols = 1'b1;
   bit               idle_on      = 1'b1;
   int unsigned      items_sent   = 0;
   int unsigned      cycle_count  = 0;

   always #10 clock = ~clock;

   best_hamming_window_match DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // -------------------------------------------------------------------------
   // Monitor: sample at the edge, before the edge's updates land. Check the
   // strobed score first; the request taken at this same edge can only
   // produce a score on a later edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) tracker.check_score(rsp_item);
         if (start && !busy) tracker.take_request(req_item);
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Pick an idle gap: mostly none, some short, a few long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic logic [SYM_W-1:0] pick_symbol();
      if (wide_symbols) return SYM_W'($urandom_range(0, 255));
      return alphabet[$urandom_range(0, 3)];
   endfunction

   // Present one request, hold it until the block takes it, then idle for a picked gap, which may be none.
   task automatic send_request(input logic cmd, input logic [SYM_W-1:0] sym,
                               input logic fin);
      req_type     r;
      int unsigned gap;
      r.command = cmd;
      r.symbol  = sym;
      r.last    = fin;
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Load a random pattern of n bytes; leave it open when close is 0.
   task automatic load_pattern(input int unsigned n, input bit close);
      for (int unsigned i = 0; i < n; i++) begin
         stim_pattern[i] = pick_symbol();
         send_request(CMD_PATTERN, stim_pattern[i], close && (i == n - 1));
      end
      stim_length = n;
   endtask

   // Stream a genome of n bytes with a copy of the pattern, sometimes mutated,
   // planted at a random offset.
   task automatic stream_genome(input int unsigned n);
      int unsigned      plen;
      int unsigned      at;
      int unsigned      flip;
      logic [SYM_W-1:0] sym;
      plen = (stim_length > PATTERN_CAP) ? PATTERN_CAP : stim_length;
      at   = $urandom_range(0, n);
      flip = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
      for (int unsigned i = 0; i < n; i++) begin
         if (i >= at && i - at < plen && $urandom_range(0, 99) >= flip)
            sym = stim_pattern[i - at];
         else
            sym = pick_symbol();
         send_request(CMD_GENOME, sym, i == n - 1);
      end
   endtask

   function automatic int unsigned pick_pattern_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return $urandom_range(1, 8);
      if (roll < 88) return $urandom_range(9, PATTERN_CAP - 1);
      if (roll < 94) return PATTERN_CAP;
      // overlong: tail bytes are dropped, last on a dropped byte still closes
      return $urandom_range(PATTERN_CAP + 1, PATTERN_CAP + 4);
   endfunction

   function automatic int unsigned pick_genome_length();
      int unsigned plen;
      plen = (stim_length > PATTERN_CAP) ? PATTERN_CAP : stim_length;
      if (plen == 0) return $urandom_range(1, 5);
      // sometimes shorter than the pattern
      if (plen > 1 && $urandom_range(0, 99) < 15) return $urandom_range(1, plen - 1);
      return $urandom_range(plen, plen + 12);
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned choice;
      int unsigned burst;

      // hold reset, then release once
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // genome with no pattern loaded: empty pattern, all-zero score
      send_request(CMD_GENOME, 8'hFF, 1'b1);
      // one-byte pattern, one hit
      send_request(CMD_PATTERN, 8'h00, 1'b1);
      send_request(CMD_GENOME, 8'h00, 1'b0);
      send_request(CMD_GENOME, 8'hFF, 1'b1);
      // new pattern replaces the old one; genome too short for it
      send_request(CMD_PATTERN, 8'hFF, 1'b0);
      send_request(CMD_PATTERN, 8'h00, 1'b0);
      send_request(CMD_PATTERN, 8'hA5, 1'b1);
      send_request(CMD_GENOME, 8'hFF, 1'b0);
      send_request(CMD_GENOME, 8'h00, 1'b1);
      // next genome reuses the pattern: full match at offset one
      send_request(CMD_GENOME, 8'h5A, 1'b0);
      send_request(CMD_GENOME, 8'hFF, 1'b0);
      send_request(CMD_GENOME, 8'h00, 1'b0);
      send_request(CMD_GENOME, 8'hA5, 1'b1);
      // pattern left open; the genome byte closes it
      send_request(CMD_PATTERN, 8'h11, 1'b0);
      send_request(CMD_PATTERN, 8'h22, 1'b0);
      send_request(CMD_GENOME, 8'h11, 1'b0);
      send_request(CMD_GENOME, 8'h22, 1'b1);
      // no position ever matches
      send_request(CMD_GENOME, 8'hEE, 1'b0);
      send_request(CMD_GENOME, 8'hEE, 1'b0);
      send_request(CMD_GENOME, 8'hEE, 1'b1);
      // at-capacity pattern and exact genome copy: top score
      wide_symbols = 1'b1;
      load_pattern(PATTERN_CAP, 1'b1);
      for (int unsigned i = 0; i < PATTERN_CAP; i++)
         send_request(CMD_GENOME, stim_pattern[i], i == PATTERN_CAP - 1);

      // --- random part ---
      while (items_sent < ITEM_TARGET) begin
         // some sequences run back to back with no idling at all
         idle_on      = $urandom_range(0, 3) != 0;
         wide_symbols = $urandom_range(0, 3) == 0;
         foreach (alphabet[i]) alphabet[i] = SYM_W'($urandom_range(0, 255));
         choice = $urandom_range(0, 99);
         if (choice < 8) begin
            // noise: any command, any last
            burst = $urandom_range(1, 4);
            repeat (burst)
               send_request(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            stim_length = 0;
         end else begin
            // well-formed: new pattern most of the time, else keep the pattern
            if (choice < 80 || stim_length == 0)
               load_pattern(pick_pattern_length(), $urandom_range(0, 19) != 0);
            stream_genome(pick_genome_length());
         end
      end

      // drop start and drain the remaining scores
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
